@@ rtl/core/ssl_pkg.sv @@
package ssl_pkg;

    localparam int LIST_DEPTH   = 64;
    localparam int SCORE_BITS   = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int ADDR_BITS    = $clog2(LIST_DEPTH);
    localparam int CNT_BITS     = $clog2(LIST_DEPTH + 1);
    localparam int KIND_BITS    = 3;
    localparam int STATUS_BITS  = 2;

    // operation kinds
    localparam logic [KIND_BITS-1:0] K_INSERT   = 3'd0;
    localparam logic [KIND_BITS-1:0] K_REM_EQ   = 3'd1;
    localparam logic [KIND_BITS-1:0] K_REM_LOW  = 3'd2;
    localparam logic [KIND_BITS-1:0] K_REM_HIGH = 3'd3;
    localparam logic [KIND_BITS-1:0] K_LOCATE   = 3'd4;
    localparam logic [KIND_BITS-1:0] K_READ     = 3'd5;
    localparam logic [KIND_BITS-1:0] K_CLEAR    = 3'd6;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [KIND_BITS-1:0]        kind;
        logic signed [SCORE_BITS-1:0] score;
        logic [PAYLOAD_BITS-1:0]     payload;
        logic [ADDR_BITS-1:0]        position;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_BITS-1:0]       status;
        logic [ADDR_BITS-1:0]         found_position;
        logic signed [SCORE_BITS-1:0] found_score;
        logic [PAYLOAD_BITS-1:0]      found_payload;
        logic [CNT_BITS-1:0]          entry_count;
    } t_out_word;

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] score;
        logic [PAYLOAD_BITS-1:0]      payload;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_WNEW,
        S_FIN
    } t_state;

endpackage

@@ rtl/core/ssl_ram.sv @@
module ssl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/sorted_score_list.sv @@
// Sorted list of up to 64 entries, ascending by signed score, held in one
// single-port-read RAM and walked by a small sequencer, entry by entry (RAM
// read, then compare or move). Insert walks down from the top, moving each
// larger entry up by one, then writes the new entry; into an empty list the
// new entry is written straight away. Remove-equal and locate scan up from
// position 0; a removal then closes the gap, moving each entry above it down
// by one. Read, remove-lowest and remove-highest touch one entry (plus the
// gap closing for remove-lowest). Clear, a full-list insert and an unused
// kind skip the RAM and go straight to the result. The block takes one word
// at a time; the result sits in an output register, so the next word is
// taken while it waits.
module sorted_score_list (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ssl_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ssl_pkg::t_out_word o_out_word
);

    ssl_pkg::t_state                         r_state, n_state;
    logic [ssl_pkg::KIND_BITS-1:0]           r_kind, n_kind;
    logic signed [ssl_pkg::SCORE_BITS-1:0]   r_key, n_key;
    logic [ssl_pkg::PAYLOAD_BITS-1:0]        r_pay, n_pay;
    logic [ssl_pkg::ADDR_BITS-1:0]           r_idx, n_idx;
    logic [ssl_pkg::CNT_BITS-1:0]            r_count, n_count;
    ssl_pkg::t_out_word                      r_res, n_res;
    ssl_pkg::t_out_word                      r_out, n_out;
    logic                                    r_out_valid, n_out_valid;

    logic                                    ram_we;
    logic [ssl_pkg::ADDR_BITS-1:0]           ram_waddr;
    ssl_pkg::t_entry                         ram_wdata;
    logic                                    ram_re;
    ssl_pkg::t_entry                         ram_rdata;

    logic                                    is_last;
    logic                                    hit;

    ssl_ram #(
        .WIDTH (ssl_pkg::ENTRY_BITS),
        .DEPTH (ssl_pkg::LIST_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign is_last = (ssl_pkg::CNT_BITS'({1'b0, r_idx}) + ssl_pkg::CNT_BITS'(1)) == r_count;
    assign hit = (r_kind == ssl_pkg::K_REM_EQ || r_kind == ssl_pkg::K_LOCATE)
               ? (ram_rdata.score == r_key) : 1'b1;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_key       = r_key;
        n_pay       = r_pay;
        n_idx       = r_idx;
        n_count     = r_count;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        o_in_ready  = (r_state == ssl_pkg::S_IDLE);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ssl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_in_word.kind;
                    n_key   = i_in_word.score;
                    n_pay   = i_in_word.payload;
                    n_res   = '0;
                    n_res.status = ssl_pkg::ST_MISS;
                    n_state = ssl_pkg::S_FIN;
                    unique case (i_in_word.kind)
                        ssl_pkg::K_INSERT: begin
                            if (r_count == ssl_pkg::CNT_BITS'(ssl_pkg::LIST_DEPTH)) begin
                                n_res.status = ssl_pkg::ST_FULL;
                            end else if (r_count == '0) begin
                                n_state = ssl_pkg::S_WNEW;
                            end else begin
                                n_idx   = r_count[ssl_pkg::ADDR_BITS-1:0]
                                        - ssl_pkg::ADDR_BITS'(1);
                                n_state = ssl_pkg::S_RD;
                            end
                        end
                        ssl_pkg::K_REM_EQ, ssl_pkg::K_LOCATE, ssl_pkg::K_REM_LOW: begin
                            if (r_count != '0) begin
                                n_idx   = '0;
                                n_state = ssl_pkg::S_RD;
                            end
                        end
                        ssl_pkg::K_REM_HIGH: begin
                            if (r_count != '0) begin
                                n_idx   = r_count[ssl_pkg::ADDR_BITS-1:0]
                                        - ssl_pkg::ADDR_BITS'(1);
                                n_state = ssl_pkg::S_RD;
                            end
                        end
                        ssl_pkg::K_READ: begin
                            if (ssl_pkg::CNT_BITS'({1'b0, i_in_word.position}) < r_count) begin
                                n_idx   = i_in_word.position;
                                n_state = ssl_pkg::S_RD;
                            end
                        end
                        ssl_pkg::K_CLEAR: begin
                            n_count      = '0;
                            n_res.status = ssl_pkg::ST_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ssl_pkg::S_RD: begin
                ram_re  = 1'b1;
                n_state = ssl_pkg::S_CMP;
            end
            ssl_pkg::S_CMP: begin
                if (r_kind == ssl_pkg::K_INSERT) begin
                    if ($signed(ram_rdata.score) > $signed(r_key)) begin
                        // move the larger entry up one slot and keep walking down
                        ram_we    = 1'b1;
                        ram_waddr = r_idx + ssl_pkg::ADDR_BITS'(1);
                        if (r_idx == '0) begin
                            n_res.found_position = '0;
                            n_state = ssl_pkg::S_WNEW;
                        end else begin
                            n_idx   = r_idx - ssl_pkg::ADDR_BITS'(1);
                            n_state = ssl_pkg::S_RD;
                        end
                    end else begin
                        n_res.found_position = r_idx + ssl_pkg::ADDR_BITS'(1);
                        n_state = ssl_pkg::S_WNEW;
                    end
                end else if (hit) begin
                    n_res.status         = ssl_pkg::ST_DONE;
                    n_res.found_position = r_idx;
                    n_res.found_score    = ram_rdata.score;
                    n_res.found_payload  = ram_rdata.payload;
                    if (r_kind == ssl_pkg::K_LOCATE || r_kind == ssl_pkg::K_READ) begin
                        n_state = ssl_pkg::S_FIN;
                    end else if (is_last) begin
                        n_count = r_count - ssl_pkg::CNT_BITS'(1);
                        n_state = ssl_pkg::S_FIN;
                    end else begin
                        n_idx   = r_idx + ssl_pkg::ADDR_BITS'(1);
                        n_state = ssl_pkg::S_SH_RD;
                    end
                end else if (is_last) begin
                    n_state = ssl_pkg::S_FIN;
                end else begin
                    n_idx   = r_idx + ssl_pkg::ADDR_BITS'(1);
                    n_state = ssl_pkg::S_RD;
                end
            end
            ssl_pkg::S_SH_RD: begin
                ram_re  = 1'b1;
                n_state = ssl_pkg::S_SH_WR;
            end
            ssl_pkg::S_SH_WR: begin
                // close the gap: move entry down one slot
                ram_we    = 1'b1;
                ram_waddr = r_idx - ssl_pkg::ADDR_BITS'(1);
                if (is_last) begin
                    n_count = r_count - ssl_pkg::CNT_BITS'(1);
                    n_state = ssl_pkg::S_FIN;
                end else begin
                    n_idx   = r_idx + ssl_pkg::ADDR_BITS'(1);
                    n_state = ssl_pkg::S_SH_RD;
                end
            end
            ssl_pkg::S_WNEW: begin
                ram_we               = 1'b1;
                ram_waddr            = r_res.found_position;
                ram_wdata.score      = r_key;
                ram_wdata.payload    = r_pay;
                n_count              = r_count + ssl_pkg::CNT_BITS'(1);
                n_res.status         = ssl_pkg::ST_DONE;
                n_res.found_score    = r_key;
                n_res.found_payload  = r_pay;
                n_state              = ssl_pkg::S_FIN;
            end
            ssl_pkg::S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out             = r_res;
                    n_out.entry_count = r_count;
                    n_out_valid       = 1'b1;
                    n_state           = ssl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssl_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_kind <= n_kind;
        r_key  <= n_key;
        r_pay  <= n_pay;
        r_idx  <= n_idx;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("block ready right after taking a word");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ssl_pkg::CNT_BITS'(ssl_pkg::LIST_DEPTH))
        else $error("entry count above list depth");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != ssl_pkg::ST_DONE)
        |-> (o_out_word.found_position == '0 && o_out_word.found_score == '0
             && o_out_word.found_payload == '0))
        else $error("failed result carries entry data");

endmodule

@@ dv/tb_sorted_score_list.sv @@
module tb_sorted_score_list;
    timeunit 1ns;
    timeprecision 1ps;

    import ssl_pkg::*;

    localparam logic [KIND_BITS-1:0] K_UNUSED = 3'd7;
    localparam int RANDOM_WORDS = 860;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_TIES} t_mode;

    typedef struct {
        t_in_word  w;
        int        rep;
        bit        typed;
        t_out_word exp_word;
    } t_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    // shadow copy of the list contents
    logic signed [SCORE_BITS-1:0] shadow_score [LIST_DEPTH];
    logic [PAYLOAD_BITS-1:0]      shadow_pay   [LIST_DEPTH];
    int                           shadow_len = 0;

    t_out_word pending_results [$];
    t_row      dir_tab [$];
    int        mism = 0;
    int        idle_cycles = 0;
    bit        calm = 1'b0;

    logic [KIND_BITS-1:0] common_ops [6] = '{K_INSERT, K_REM_EQ, K_REM_LOW,
                                            K_REM_HIGH, K_LOCATE, K_READ};
    logic [KIND_BITS-1:0] remove_ops [3] = '{K_REM_EQ, K_REM_LOW, K_REM_HIGH};

    sorted_score_list uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_out_word list_op_result(input t_in_word w);
        t_out_word r;
        int        at;
        int        i;
        bit        hit;
        bit        drop;
        r = '0;
        r.status = ST_MISS;
        at = 0;
        hit = 1'b0;
        drop = 1'b0;
        case (w.kind)
            K_INSERT: begin
                if (shadow_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // new word goes after every score that is equal or lower
                    at = shadow_len;
                    for (i = 0; i < shadow_len; i++) begin
                        if ($signed(shadow_score[i]) > $signed(w.score)) begin
                            at = i;
                            break;
                        end
                    end
                    for (i = shadow_len; i > at; i--) begin
                        shadow_score[i] = shadow_score[i-1];
                        shadow_pay[i]   = shadow_pay[i-1];
                    end
                    shadow_score[at] = w.score;
                    shadow_pay[at]   = w.payload;
                    shadow_len++;
                    hit = 1'b1;
                end
            end
            K_REM_EQ, K_LOCATE: begin
                for (i = 0; i < shadow_len; i++) begin
                    if (shadow_score[i] == w.score) begin
                        at = i;
                        hit = 1'b1;
                        drop = (w.kind == K_REM_EQ);
                        break;
                    end
                end
            end
            K_REM_LOW: begin
                if (shadow_len > 0) begin
                    at = 0;
                    hit = 1'b1;
                    drop = 1'b1;
                end
            end
            K_REM_HIGH: begin
                if (shadow_len > 0) begin
                    at = shadow_len - 1;
                    hit = 1'b1;
                    drop = 1'b1;
                end
            end
            K_READ: begin
                if (int'(w.position) < shadow_len) begin
                    at = int'(w.position);
                    hit = 1'b1;
                end
            end
            K_CLEAR: begin
                shadow_len = 0;
                r.status = ST_DONE;
            end
            default: ;
        endcase
        if (hit) begin
            r.status         = ST_DONE;
            r.found_position = at[ADDR_BITS-1:0];
            r.found_score    = shadow_score[at];
            r.found_payload  = shadow_pay[at];
            if (drop) begin
                for (i = at; i + 1 < shadow_len; i++) begin
                    shadow_score[i] = shadow_score[i+1];
                    shadow_pay[i]   = shadow_pay[i+1];
                end
                shadow_len--;
            end
        end
        r.entry_count = shadow_len[CNT_BITS-1:0];
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_word draw_word(input t_mode mode);
        t_in_word w;
        int       r;
        int       s;
        w.score    = SCORE_BITS'($urandom);
        w.payload  = PAYLOAD_BITS'($urandom);
        w.position = ADDR_BITS'($urandom);
        r = $urandom_range(0, 99);
        if (mode == MODE_FILL && r < 70) begin
            w.kind = K_INSERT;
        end else if (mode == MODE_DRAIN && r < 65) begin
            w.kind = remove_ops[$urandom_range(0, 2)];
        end else begin
            r = $urandom_range(0, 99);
            if (r < 2)
                w.kind = K_CLEAR;
            else if (r < 4)
                w.kind = K_UNUSED;
            else
                w.kind = common_ops[$urandom_range(0, 5)];
        end
        if (mode == MODE_TIES) begin
            s = int'($urandom_range(0, 8)) - 4;
            w.score = s[SCORE_BITS-1:0];
        end
        if ($urandom_range(0, 99) < 4)
            w.score = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        // aim most key lookups at a score that is actually held
        if ((w.kind == K_REM_EQ || w.kind == K_LOCATE) && shadow_len > 0
                && $urandom_range(0, 3) != 0)
            w.score = shadow_score[$urandom_range(0, shadow_len - 1)];
        if (w.kind == K_READ && shadow_len > 0 && $urandom_range(0, 4) != 0)
            w.position = ADDR_BITS'($urandom_range(0, shadow_len - 1));
        return w;
    endfunction

    task automatic issue(input t_in_word w, input bit typed, input t_out_word given);
        int        gap;
        t_out_word pred;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pred = list_op_result(w);
        pending_results.push_back(typed ? given : pred);
    endtask

    task automatic add_row(input logic [KIND_BITS-1:0] kind,
                           input logic [SCORE_BITS-1:0] score,
                           input logic [PAYLOAD_BITS-1:0] payload,
                           input logic [ADDR_BITS-1:0] position, input int rep);
        t_row row;
        row.w        = '{kind, score, payload, position};
        row.rep      = rep;
        row.typed    = 1'b0;
        row.exp_word = '0;
        dir_tab.push_back(row);
    endtask

    task automatic add_chk(input logic [KIND_BITS-1:0] kind,
                           input logic [SCORE_BITS-1:0] score,
                           input logic [PAYLOAD_BITS-1:0] payload,
                           input logic [ADDR_BITS-1:0] position,
                           input logic [STATUS_BITS-1:0] st,
                           input logic [ADDR_BITS-1:0] fpos,
                           input logic [SCORE_BITS-1:0] fscore,
                           input logic [PAYLOAD_BITS-1:0] fpay,
                           input logic [CNT_BITS-1:0] cnt);
        t_row row;
        row.w        = '{kind, score, payload, position};
        row.rep      = 1;
        row.typed    = 1'b1;
        row.exp_word = '{st, fpos, fscore, fpay, cnt};
        dir_tab.push_back(row);
    endtask

    task automatic check_field(input string fld, input logic [31:0] want, got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, fld, want, got);
            mism++;
        end
    endtask

    // result side
    initial begin
        t_out_word want;
        int        gap;
        wait (rst_n);
        forever begin
            gap = gap_len();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h",
                         $time, out_word);
                mism++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(out_word.status));
                check_field("found_position", 32'(want.found_position),
                            32'(out_word.found_position));
                check_field("found_score", 32'(want.found_score),
                            32'(out_word.found_score));
                check_field("found_payload", 32'(want.found_payload),
                            32'(out_word.found_payload));
                check_field("entry_count", 32'(want.entry_count),
                            32'(out_word.entry_count));
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                    $display("sorted_score_list regression: fail");
                    $finish;
                end
            end
        end
    end

    initial begin
        t_in_word w;
        t_mode    mode;
        int       k;
        int       span;
        int       sent;
        bit       first;

        // empty list
        add_chk(K_REM_LOW, 16'sh0000, 32'h0, 6'd0, ST_MISS, 6'd0, 16'sh0, 32'h0, 7'd0);
        add_chk(K_REM_HIGH, 16'sh0000, 32'h0, 6'd0, ST_MISS, 6'd0, 16'sh0, 32'h0, 7'd0);
        add_chk(K_READ, 16'sh0000, 32'h0, 6'd0, ST_MISS, 6'd0, 16'sh0, 32'h0, 7'd0);
        add_chk(K_LOCATE, 16'sh0000, 32'h0, 6'd0, ST_MISS, 6'd0, 16'sh0, 32'h0, 7'd0);
        add_chk(K_REM_EQ, 16'sh0000, 32'h0, 6'd0, ST_MISS, 6'd0, 16'sh0, 32'h0, 7'd0);
        add_chk(K_UNUSED, 16'sh7FFF, 32'hFFFF_FFFF, 6'd63, ST_MISS, 6'd0, 16'sh0,
                32'h0, 7'd0);
        // extremes, then equal scores keep arrival order
        add_chk(K_INSERT, 16'sh7FFF, 32'hFFFF_FFFF, 6'd0, ST_DONE, 6'd0, 16'sh7FFF,
                32'hFFFF_FFFF, 7'd1);
        add_chk(K_INSERT, 16'sh8000, 32'h0, 6'd63, ST_DONE, 6'd0, 16'sh8000, 32'h0, 7'd2);
        add_chk(K_INSERT, 16'sh0000, 32'hA5A5_A5A5, 6'd0, ST_DONE, 6'd1, 16'sh0,
                32'hA5A5_A5A5, 7'd3);
        add_chk(K_INSERT, 16'sh0000, 32'h5A5A_5A5A, 6'd0, ST_DONE, 6'd2, 16'sh0,
                32'h5A5A_5A5A, 7'd4);
        add_chk(K_LOCATE, 16'sh0000, 32'h0, 6'd0, ST_DONE, 6'd1, 16'sh0,
                32'hA5A5_A5A5, 7'd4);
        add_chk(K_LOCATE, 16'sh1234, 32'h0, 6'd0, ST_MISS, 6'd0, 16'sh0, 32'h0, 7'd4);
        add_chk(K_READ, 16'sh0000, 32'h0, 6'd63, ST_MISS, 6'd0, 16'sh0, 32'h0, 7'd4);
        add_chk(K_READ, 16'sh0000, 32'h0, 6'd3, ST_DONE, 6'd3, 16'sh7FFF,
                32'hFFFF_FFFF, 7'd4);
        add_chk(K_REM_EQ, 16'sh0000, 32'h0, 6'd0, ST_DONE, 6'd1, 16'sh0,
                32'hA5A5_A5A5, 7'd3);
        add_chk(K_REM_HIGH, 16'sh0000, 32'h0, 6'd0, ST_DONE, 6'd2, 16'sh7FFF,
                32'hFFFF_FFFF, 7'd2);
        add_chk(K_REM_LOW, 16'sh0000, 32'h0, 6'd0, ST_DONE, 6'd0, 16'sh8000, 32'h0, 7'd1);
        add_chk(K_CLEAR, 16'sh7FFF, 32'hFFFF_FFFF, 6'd63, ST_DONE, 6'd0, 16'sh0,
                32'h0, 7'd0);
        // fill to the top with random content, then hit the full list
        add_row(K_INSERT, 16'sh0000, 32'h0, 6'd0, LIST_DEPTH);
        add_chk(K_INSERT, 16'sh0001, 32'h1, 6'd0, ST_FULL, 6'd0, 16'sh0, 32'h0, 7'd64);
        add_row(K_READ, 16'sh0000, 32'h0, 6'd63, 1);
        add_chk(K_UNUSED, 16'sh0000, 32'h0, 6'd0, ST_MISS, 6'd0, 16'sh0, 32'h0, 7'd64);
        add_row(K_REM_HIGH, 16'sh0000, 32'h0, 6'd0, 1);
        add_row(K_REM_LOW, 16'sh0000, 32'h0, 6'd0, 1);
        add_row(K_INSERT, 16'sh7FFF, 32'h8000_0001, 6'd0, 1);
        add_chk(K_CLEAR, 16'sh0000, 32'h0, 6'd0, ST_DONE, 6'd0, 16'sh0, 32'h0, 7'd0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[n]) begin
            for (k = 0; k < dir_tab[n].rep; k++) begin
                w = dir_tab[n].w;
                // repeated rows carry fresh random content each time
                if (dir_tab[n].rep > 1) begin
                    w.score   = SCORE_BITS'($urandom);
                    w.payload = PAYLOAD_BITS'($urandom);
                end
                issue(w, dir_tab[n].typed, dir_tab[n].exp_word);
            end
        end

        sent = 0;
        first = 1'b1;
        while (sent < RANDOM_WORDS) begin
            mode = t_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 80);
            calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < span && sent < RANDOM_WORDS; k++) begin
                issue(draw_word(mode), 1'b0, '0);
                sent++;
            end
            // after the first span, and at random after later ones, hold the sender until every result is back
            if (first || $urandom_range(0, 3) == 0) begin
                in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge clk);
            end
            first = 1'b0;
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mism == 0)
            $display("sorted_score_list regression: pass");
        else
            $display("sorted_score_list regression: fail");
        $finish;
    end

endmodule
